>>> hw/rtl/name_registry_table_macros.svh
// Assertion macros for the name registry table.
// Used by the top level; no other dependencies.
`ifndef NAME_REGISTRY_TABLE_MACROS_SVH
`define NAME_REGISTRY_TABLE_MACROS_SVH

`ifndef SYNTH
`define NRT_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NRT_ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NRT_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define NRT_ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

>>> hw/rtl/nrt_pkg.sv
// Shared types and constants for the name registry table.
// No dependencies.
`timescale 1ns / 1ps

package nrt_pkg;

    localparam int TID_W       = 7;
    localparam int KEY_W       = 64;
    localparam int STATUS_W    = 3;
    localparam int NAME_CNT_W  = 2;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 24;
    localparam int OUT_PAD_W   = OUT_DATA_W - STATUS_W - 2 * TID_W;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_TASK_COUNT  = 128;
    localparam int DEF_KEY_BYTES   = 8;

    localparam logic [NAME_CNT_W-1:0] MAX_NAMES = 2'd2;

    typedef enum logic {
        KIND_REGISTER = 1'b0,
        KIND_LOOKUP   = 1'b1
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NOT_REG    = 3'd1,
        ST_MAX_NAMES  = 3'd2,
        ST_ALREADY    = 3'd3,
        ST_TABLE_FULL = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_LOOK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic shift;      // append: every cell takes its left neighbor's entry
        logic set_owner;  // overwrite owner in the hitting cell
    } t_cell_ctl;

endpackage

>>> hw/rtl/nrt_cell.sv
// One table entry of the name registry: key, owner and a registered compare.
// Depends on nrt_pkg.
`timescale 1ns / 1ps

module nrt_cell #(
    parameter int CNT_W = 7,
    parameter int IDX   = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  nrt_pkg::t_cell_ctl       i_ctl,
    input  logic [CNT_W-1:0]         i_count,
    input  logic [nrt_pkg::KEY_W-1:0] i_req_key,
    input  logic [nrt_pkg::TID_W-1:0] i_req_owner,
    input  logic [nrt_pkg::KEY_W-1:0] i_prev_key,
    input  logic [nrt_pkg::TID_W-1:0] i_prev_owner,
    output logic [nrt_pkg::KEY_W-1:0] o_key,
    output logic [nrt_pkg::TID_W-1:0] o_owner,
    output logic                     o_hit,
    output logic [nrt_pkg::TID_W-1:0] o_hit_owner
);
    import nrt_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [KEY_W-1:0] r_key;
    logic [TID_W-1:0] r_owner;
    logic             r_hit;
    logic [TID_W-1:0] r_hit_owner;
    logic             w_match;

    assign w_match = (MY_IDX < i_count) && (r_key == i_req_key);

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key   <= i_prev_key;
            r_owner <= i_prev_owner;
        end else if (i_ctl.set_owner && r_hit) begin
            r_owner <= i_req_owner;
        end
        r_hit_owner <= w_match ? r_owner : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= w_match;
        end
    end

    assign o_key       = r_key;
    assign o_owner     = r_owner;
    assign o_hit       = r_hit;
    assign o_hit_owner = r_hit_owner;

endmodule

>>> hw/rtl/name_registry_table.sv
// Top level of the name registry table: request handling, per-task name counts,
// and the row of entry cells. Depends on nrt_pkg, nrt_cell and the macro header.
`timescale 1ns / 1ps
`include "name_registry_table_macros.svh"

// Name-to-owner registry. Each request beat (tuser = kind, tdata = task id and
// name key) produces one result beat: the request is captured, then all entry
// cells compare the key in parallel, then the block decides, updates the table
// and loads the output register once that register is free. A new request is
// taken once the previous one has been decided, so requests never overlap.
// Entries are kept in a shifting row of cells; an append shifts every entry one
// cell along. After reset the per-task name counts are cleared by a sweep over
// all TASK_COUNT counters, during which no request is accepted.
module name_registry_table #(
    parameter int TABLE_DEPTH = nrt_pkg::DEF_TABLE_DEPTH,
    parameter int TASK_COUNT  = nrt_pkg::DEF_TASK_COUNT,
    parameter int KEY_BYTES   = nrt_pkg::DEF_KEY_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [nrt_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,  // task_id, name_key, pad
    input  logic                            i_s_axis_tuser,  // kind
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [nrt_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata   // status, owner_task,
                                                             // requester_echo, pad
);
    import nrt_pkg::*;

    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int CIDX_W   = $clog2(TASK_COUNT);
    localparam int TID_SPAN = 1 << TID_W;
    localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 8) ? {KEY_W{1'b1}} :
        ((KEY_W'(1) << (8 * KEY_BYTES)) - KEY_W'(1));

    t_state              r_state, n_state;
    t_kind               r_kind;
    logic [TID_W-1:0]    r_tid;
    logic [KEY_W-1:0]    r_key;
    logic [CIDX_W-1:0]   r_cidx;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CIDX_W-1:0]   r_clr_idx;

    logic [NAME_CNT_W-1:0] r_name_cnt [TASK_COUNT];
    logic [NAME_CNT_W-1:0] r_cnt_rd;
    logic                  w_mem_we;
    logic [CIDX_W-1:0]     w_mem_wa;
    logic [NAME_CNT_W-1:0] w_mem_wd;

    logic                r_out_valid;
    t_status             r_status;
    logic [TID_W-1:0]    r_owner;
    logic [TID_W-1:0]    r_echo;
    logic                w_res_load;
    t_status             w_res_status;
    logic [TID_W-1:0]    w_res_owner;

    logic [CIDX_W-1:0]   w_mod_tab [TID_SPAN];
    logic                w_in_acc;
    logic                w_out_free;
    t_cell_ctl           w_ctl;

    logic [KEY_W-1:0]       w_cell_key   [TABLE_DEPTH];
    logic [TID_W-1:0]       w_cell_owner [TABLE_DEPTH];
    logic [TID_W-1:0]       w_hit_owner  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_hits;
    logic                   w_any_hit;
    logic [TID_W-1:0]       w_found_owner;

    // task id to count index, worked out at elaboration
    for (genvar g = 0; g < TID_SPAN; g++) begin : g_mod
        assign w_mod_tab[g] = CIDX_W'(g % TASK_COUNT);
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_count     <= '0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_INIT) begin
                r_clr_idx <= r_clr_idx + CIDX_W'(1);
            end
            if (w_res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind <= t_kind'(i_s_axis_tuser);
            r_tid  <= i_s_axis_tdata[TID_W-1:0];
            r_key  <= i_s_axis_tdata[TID_W +: KEY_W] & KEY_MASK;
            r_cidx <= w_mod_tab[i_s_axis_tdata[TID_W-1:0]];
        end
        if (w_res_load) begin
            r_status <= w_res_status;
            r_owner  <= w_res_owner;
            r_echo   <= r_tid;
        end
    end

    // per-task name counts
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_name_cnt[w_mem_wa] <= w_mem_wd;
        end
        r_cnt_rd <= r_name_cnt[r_cidx];
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        w_ctl        = '0;
        w_mem_we     = 1'b0;
        w_mem_wa     = r_cidx;
        w_mem_wd     = '0;
        w_res_load   = 1'b0;
        w_res_status = ST_OK;
        w_res_owner  = '0;
        unique case (r_state)
            S_INIT: begin
                w_mem_we = 1'b1;
                w_mem_wa = r_clr_idx;
                if (r_clr_idx == CIDX_W'(TASK_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_res_load = 1'b1;
                    n_state    = S_IDLE;
                    priority if (r_kind == KIND_LOOKUP) begin
                        w_res_status = w_any_hit ? ST_OK : ST_NOT_REG;
                        w_res_owner  = w_any_hit ? w_found_owner : '0;
                    end else if (r_cnt_rd >= MAX_NAMES) begin
                        w_res_status = ST_MAX_NAMES;
                    end else if (w_any_hit) begin
                        if (w_found_owner == r_tid) begin
                            w_res_status = ST_ALREADY;
                        end else begin
                            w_res_status    = ST_OK;
                            w_ctl.set_owner = 1'b1;
                        end
                    end else if (r_count == CNT_W'(TABLE_DEPTH)) begin
                        w_res_status = ST_TABLE_FULL;
                    end else begin
                        w_res_status = ST_OK;
                        w_ctl.shift  = 1'b1;
                        n_count      = r_count + CNT_W'(1);
                        w_mem_we     = 1'b1;
                        w_mem_wd     = r_cnt_rd + NAME_CNT_W'(1);
                    end
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic [KEY_W-1:0] w_prev_key;
        logic [TID_W-1:0] w_prev_owner;
        if (g == 0) begin : g_head
            assign w_prev_key   = r_key;
            assign w_prev_owner = r_tid;
        end else begin : g_link
            assign w_prev_key   = w_cell_key[g-1];
            assign w_prev_owner = w_cell_owner[g-1];
        end
        nrt_cell #(
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_count      (r_count),
            .i_req_key    (r_key),
            .i_req_owner  (r_tid),
            .i_prev_key   (w_prev_key),
            .i_prev_owner (w_prev_owner),
            .o_key        (w_cell_key[g]),
            .o_owner      (w_cell_owner[g]),
            .o_hit        (w_hits[g]),
            .o_hit_owner  (w_hit_owner[g])
        );
    end

    // keys are unique, so at most one cell hits
    always_comb begin
        w_any_hit     = |w_hits;
        w_found_owner = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_found_owner = w_found_owner | w_hit_owner[i];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {OUT_PAD_W'(0), r_echo, r_owner, r_status};

    `NRT_ASSERT_RST(a_single_hit, i_clk, i_rst_n, $onehot0(w_hits), "more than one cell hit")
    `NRT_ASSERT_CLK(a_ctl_excl, i_clk, !(w_ctl.shift && w_ctl.set_owner), "append and overwrite together")
    `NRT_ASSERT_RST(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(TABLE_DEPTH), "entry count overflow")
    `NRT_ASSERT_RST(a_accept_look, i_clk, i_rst_n, w_in_acc |=> (r_state == S_LOOK), "accept not followed by compare")

endmodule
